// ----- src/xr128_pkg.sv -----
// Shared types and constants for the ranged xorshift128 generator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package xr128_pkg;

	localparam int WORD_W = 32;
	localparam int SPAN_W = 33;
	localparam int DRAW_W = 31;
	localparam int CNT_W = $clog2(DRAW_W);
	localparam int CMD_DEPTH_DEF = 2;

	localparam logic [WORD_W-1:0] SEED_W0 = 32'd123456789;
	localparam logic [WORD_W-1:0] SEED_W1 = 32'd362436069;
	localparam logic [WORD_W-1:0] SEED_W2 = 32'd521288629;
	localparam logic [WORD_W-1:0] SEED_W3 = 32'd88675123;

	localparam int SHIFT_A = 11;
	localparam int SHIFT_B = 8;
	localparam int SHIFT_C = 19;

	typedef struct packed {
		logic signed [WORD_W-1:0] lower_bound;
		logic signed [WORD_W-1:0] upper_bound;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic [DRAW_W-1:0]        raw_draw;
		logic                     advanced;
	} rsp_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] lower_bound;
		logic [SPAN_W-1:0]        span;
		logic [DRAW_W-1:0]        draw;
		logic                     advanced;
	} cmd_t;

	function automatic logic [WORD_W-1:0] xs_next(input logic [WORD_W-1:0] w0,
		input logic [WORD_W-1:0] w3);
		logic [WORD_W-1:0] t;
		t = w3 ^ (w3 << SHIFT_A);
		t = t ^ (t >> SHIFT_B);
		return t ^ w0 ^ (w0 >> SHIFT_C);
	endfunction

endpackage

`default_nettype wire

// ----- src/xr128_front.sv -----
// Front end: accepts requests, classifies empty ranges, steps the generator.
// Depends on xr128_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xr128_front import xr128_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	output logic full,
	input  req_t request,
	input  wire  cmd_full,
	output logic cmd_push,
	output cmd_t cmd
);

	logic [WORD_W-1:0] gen_q [4];
	logic [WORD_W-1:0] w0_next;
	logic              in_range;
	logic              accept;

	assign full = cmd_full;
	assign accept = push && !cmd_full;
	assign in_range = request.upper_bound > request.lower_bound;
	assign w0_next = xs_next(gen_q[0], gen_q[3]);

	always_comb begin
		cmd.lower_bound = request.lower_bound;
		cmd.span = {request.upper_bound[WORD_W-1], request.upper_bound}
			- {request.lower_bound[WORD_W-1], request.lower_bound} + SPAN_W'(1);
		cmd.draw = in_range ? w0_next[DRAW_W-1:0] : '0;
		cmd.advanced = in_range;
	end

	assign cmd_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q[0] <= SEED_W0;
			gen_q[1] <= SEED_W1;
			gen_q[2] <= SEED_W2;
			gen_q[3] <= SEED_W3;
		end else if (accept && in_range) begin
			gen_q[0] <= w0_next;
			gen_q[1] <= gen_q[0];
			gen_q[2] <= gen_q[1];
			gen_q[3] <= gen_q[2];
		end
	end

endmodule

`default_nettype wire

// ----- src/xr128_cmd_fifo.sv -----
// Short command queue between the front end and the remainder unit.
// Depends on xr128_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xr128_cmd_fifo import xr128_pkg::*; #(
	parameter int DEPTH = CMD_DEPTH_DEF
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  cmd_t wdata,
	output logic full,
	input  wire  pop,
	output cmd_t rdata,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_FW = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_FW-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = count_q == CNT_FW'(DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_FW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_FW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/xr128_back.sv -----
// Back end: radix-2 remainder of the draw by the span, offset add, result register.
// Depends on xr128_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xr128_back import xr128_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  cmd_empty,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic empty,
	input  wire  pop,
	output rsp_t result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]               state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [SPAN_W-1:0]        rem_q;
	logic [SPAN_W-1:0]        span_q;
	logic [DRAW_W-1:0]        dividend_q;
	logic [DRAW_W-1:0]        draw_q;
	logic signed [WORD_W-1:0] lower_q;
	logic                     adv_q;
	logic                     out_valid_q;
	rsp_t                     out_q;
	logic [SPAN_W:0]          rem_shift;
	logic [SPAN_W:0]          rem_sub;
	logic [SPAN_W-1:0]        rem_next;
	logic                     out_free;

	assign empty = !out_valid_q;
	assign result = out_q;
	assign out_free = !out_valid_q || pop;
	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;

	assign rem_shift = {rem_q, dividend_q[DRAW_W-1]};
	assign rem_sub = rem_shift - {1'b0, span_q};
	assign rem_next = rem_sub[SPAN_W] ? rem_shift[SPAN_W-1:0] : rem_sub[SPAN_W-1:0];

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				lower_q <= cmd.lower_bound;
				span_q <= cmd.span;
				dividend_q <= cmd.draw;
				draw_q <= cmd.draw;
				adv_q <= cmd.advanced;
				rem_q <= '0;
				cnt_q <= CNT_W'(DRAW_W - 1);
			end
			ST_RUN: begin
				rem_q <= rem_next;
				dividend_q <= dividend_q << 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.value <= lower_q + $signed(rem_q[WORD_W-1:0]);
					out_q.raw_draw <= draw_q;
					out_q.advanced <= adv_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						state_q <= cmd.advanced ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rem_q < span_q))
		else $error("remainder reached the span");

	a_done_writes_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished word not written to the result register");

	a_idle_draw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.advanced) |-> (out_q.raw_draw == '0))
		else $error("nonzero draw on a word that did not step the generator");

	a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN || state_q == ST_DONE) |-> !cmd_pop)
		else $error("command taken while the remainder unit is busy");
`endif

endmodule

`default_nettype wire

// ----- src/xorshift128_ranged_random.sv -----
// Top level of the ranged xorshift128 generator: front end, command queue, back end.
// Depends on xr128_pkg, xr128_front, xr128_cmd_fifo and xr128_back.
//
//   channel   handshake         word
//   request   push / full       req_t  (lower_bound, upper_bound)
//   result    pop / empty       rsp_t  (value, raw_draw, advanced)
//
// In the back end a request with a nonempty range goes through one load,
// 31 remainder steps of the shared subtractor, and one result write.
// An empty range bypasses the remainder loop and goes from the load to the write.
// Reset loads the four seed words; there is no clearing pass.
// CMD_DEPTH requests queue between the front and back ends; the result
// register holds one finished word while the next one is computed.
`timescale 1ns / 1ps
`default_nettype none

module xorshift128_ranged_random import xr128_pkg::*; #(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	output logic full,
	input  req_t request,
	output logic empty,
	input  wire  pop,
	output rsp_t result
);

	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;

	xr128_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	xr128_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	xr128_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

`default_nettype wire
